@@ hw/rtl/zlcmd_pkg.sv @@
// Shared types and constants of the zone line centroid mean distance block.
package zlcmd_pkg;

	// Field widths of the pixel and result items.
	localparam int PIX_W      = 8;
	localparam int MEAN_W     = 17;
	localparam int CNT_W      = 9;
	localparam int SUM_W      = 25;

	// Fraction bits of a distance and of the mean.
	localparam int FRAC_BITS  = 8;

	// Foreground pixel value.
	localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;

	// Largest value of the saturating foreground count accumulator.
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Square of a distance: sum of two squared 8-bit differences.
	localparam int SQ_W       = 2 * PIX_W + 1;

	// Square root unit: radicand is the square scaled by 2^(2*FRAC_BITS).
	// The root width is rounded up to a whole number of cycles.
	localparam int ROOT_STEPS_PER_CYC = 3;
	localparam int ROOT_MIN_W = (SQ_W + 2 * FRAC_BITS + 1) / 2;
	localparam int ROOT_W     = ((ROOT_MIN_W + ROOT_STEPS_PER_CYC - 1) / ROOT_STEPS_PER_CYC)
		* ROOT_STEPS_PER_CYC;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int REM_W      = ROOT_W + 3;
	localparam int ROOT_CYC   = ROOT_W / ROOT_STEPS_PER_CYC;
	localparam int ROOT_CNT_W = (ROOT_CYC > 1) ? $clog2(ROOT_CYC) : 1;

	// Rounded distance width.
	localparam int DIST_W     = MEAN_W;

	// Divider: one quotient bit per cycle over the whole sum.
	localparam int DIV_STEPS  = SUM_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// Queue between the front and the back; depth must be a power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = PIX_W;
	localparam logic [CFG_IDX_W-1:0] REG_CENTROID_ROW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTROID_COL = 1'd1;
	localparam logic [PIX_W-1:0] CENTROID_RESET = 8'd25;

	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SUM_W-1:0]  sum_t;

	// One classified item handed from the front to the back.
	typedef struct packed {
		dist_t distance;
		logic  fg;
		logic  last;
	} item_t;

	// Write side of the queue.
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_push_t;

	// Read side of the queue.
	typedef struct packed {
		logic  empty;
		item_t head;
	} q_head_t;

endpackage

@@ hw/rtl/zlcmd_pixel_if.sv @@
// Pixel channel: valid/ready handshake with one pixel item as payload.
interface zlcmd_pixel_if;
	logic valid;
	logic ready;
	logic [zlcmd_pkg::PIX_W-1:0] pixel_value;
	logic [zlcmd_pkg::PIX_W-1:0] pixel_row;
	logic [zlcmd_pkg::PIX_W-1:0] pixel_col;
	logic line_end;

	modport source (output valid, pixel_value, pixel_row, pixel_col, line_end, input ready);
	modport sink (input valid, pixel_value, pixel_row, pixel_col, line_end, output ready);
endinterface

@@ hw/rtl/zlcmd_result_if.sv @@
// Result channel: valid/ready handshake with one line result as payload.
interface zlcmd_result_if;
	logic valid;
	logic ready;
	logic [zlcmd_pkg::MEAN_W-1:0] mean_distance;
	logic [zlcmd_pkg::CNT_W-1:0]  foreground_count;

	modport source (output valid, mean_distance, foreground_count, input ready);
	modport sink (input valid, mean_distance, foreground_count, output ready);
endinterface

@@ hw/rtl/zone_line_centroid_mean_distance_core.sv @@
// Top level of the zone line centroid mean distance block.
//
// Pixels of one zone line enter on the pixel channel, each with its row,
// column and a line_end mark on the last pixel of the line. One result per
// line leaves on the result channel: the truncated mean distance of the
// foreground pixels to the centroid (unsigned Q9.8, 0 for an empty line)
// and their count. The user must set the centroid through the write port
// only while idle; the block itself does not enforce it. A foreground
// pixel holds the front while it squares the differences, runs the square
// root unit at 3 digits a cycle, and rounds and queues the root. A
// background pixel is queued only at a line end, and holds the front
// until its item is queued. The back drains the 4-entry queue at one item
// a cycle while it accumulates; at a line end its one-bit-per-cycle
// divider runs over the whole sum, then the output register is loaded.
// The front keeps taking pixels while the back divides, until the queue
// fills. A stalled result waits in the output register; the back holds when
// its next result is due; the front fills the queue, then takes no pixels.
// Reset clears the accumulators, the queue and the output valid and sets
// both centroid coordinates to 25.
module zone_line_centroid_mean_distance_core (
	input  logic                              clk,
	input  logic                              arst_n,
	zlcmd_pixel_if.sink                       pixel,
	zlcmd_result_if.source                    result,
	input  logic                              cfg_we,
	input  logic [zlcmd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [zlcmd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	zlcmd_pkg::q_push_t q_push;
	zlcmd_pkg::q_head_t q_head;
	logic               q_full;
	logic               pop;

	// Pixel intake, classification and distance.
	zlcmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push)
	);

	// Decoupling queue.
	zlcmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_full (q_full),
		.pop    (pop),
		.q_head (q_head)
	);

	// Accumulation, division and result register.
	zlcmd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_head (q_head),
		.pop    (pop),
		.result (result)
	);

endmodule

@@ hw/rtl/zlcmd_front.sv @@
// Front end: accepts pixels, holds the centroid and computes the rounded distance.
module zlcmd_front (
	input  logic                               clk,
	input  logic                               arst_n,
	zlcmd_pixel_if.sink                        pixel,
	input  logic                               cfg_we,
	input  logic [zlcmd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [zlcmd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               q_full,
	output zlcmd_pkg::q_push_t                 q_push
);

	typedef logic [zlcmd_pkg::REM_W-1:0]      rem_t;
	typedef logic [zlcmd_pkg::ROOT_W-1:0]     root_t;
	typedef logic [zlcmd_pkg::RAD_W-1:0]      rad_t;
	typedef logic [zlcmd_pkg::SQ_W-1:0]       sq_t;
	typedef logic [zlcmd_pkg::ROOT_CNT_W-1:0] rcnt_t;
	typedef logic [zlcmd_pkg::PIX_W-1:0]      pix_t;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_ROOT = 3'b010,
		F_PUSH = 3'b100
	} state_t;

	typedef struct packed {
		rem_t  rem;
		root_t root;
		rad_t  rad;
	} sqrt_st_t;

	// One digit of the digit-by-digit square root.
	function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
		sqrt_st_t n;
		rem_t     shifted;
		rem_t     trial;
		shifted = {s.rem[zlcmd_pkg::REM_W-3:0], s.rad[zlcmd_pkg::RAD_W-1 -: 2]};
		trial   = rem_t'({s.root, 2'b01});
		n.rad   = s.rad << 2;
		if (shifted >= trial) begin
			n.rem  = shifted - trial;
			n.root = {s.root[zlcmd_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			n.rem  = shifted;
			n.root = {s.root[zlcmd_pkg::ROOT_W-2:0], 1'b0};
		end
		return n;
	endfunction

	state_t   state_q;
	rcnt_t    step_q;
	pix_t     crow_q;
	pix_t     ccol_q;
	sqrt_st_t sqrt_q;
	logic     fg_q;
	logic     last_q;

	logic     accept;
	logic     fg;
	pix_t     dr;
	pix_t     dc;
	sq_t      sq;
	sqrt_st_t sqrt_next;
	root_t    root_rnd;

	assign pixel.ready = (state_q == F_IDLE);
	assign accept      = pixel.valid && pixel.ready;
	assign fg          = (pixel.pixel_value == zlcmd_pkg::FG_VALUE);

	// Absolute coordinate differences and the squared distance.
	always_comb begin
		dr = (pixel.pixel_row >= crow_q) ? pixel.pixel_row - crow_q : crow_q - pixel.pixel_row;
		dc = (pixel.pixel_col >= ccol_q) ? pixel.pixel_col - ccol_q : ccol_q - pixel.pixel_col;
		sq = sq_t'(dr) * sq_t'(dr) + sq_t'(dc) * sq_t'(dc);
	end

	// Several root digits per cycle.
	always_comb begin
		sqrt_next = sqrt_q;
		for (int i = 0; i < zlcmd_pkg::ROOT_STEPS_PER_CYC; i++) begin
			sqrt_next = sqrt_step(sqrt_next);
		end
	end

	// Round to nearest: the remainder exceeds the root when the true root is past the half.
	always_comb begin
		if (sqrt_q.rem > rem_t'(sqrt_q.root)) begin
			root_rnd = sqrt_q.root + root_t'(1);
		end else begin
			root_rnd = sqrt_q.root;
		end
	end

	assign q_push.valid         = (state_q == F_PUSH) && !q_full;
	assign q_push.item.distance = zlcmd_pkg::dist_t'(root_rnd);
	assign q_push.item.fg       = fg_q;
	assign q_push.item.last     = last_q;

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			crow_q  <= zlcmd_pkg::CENTROID_RESET;
			ccol_q  <= zlcmd_pkg::CENTROID_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					zlcmd_pkg::REG_CENTROID_ROW: crow_q <= cfg_data;
					zlcmd_pkg::REG_CENTROID_COL: ccol_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						step_q <= '0;
						if (fg) begin
							state_q <= F_ROOT;
						end else if (pixel.line_end) begin
							state_q <= F_PUSH;
						end
					end
				end
				F_ROOT: begin
					step_q <= step_q + rcnt_t'(1);
					if (step_q == rcnt_t'(zlcmd_pkg::ROOT_CYC - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Root datapath; a background pixel leaves a zero root.
	always_ff @(posedge clk) begin
		if (accept) begin
			fg_q        <= fg;
			last_q      <= pixel.line_end;
			sqrt_q.rem  <= '0;
			sqrt_q.root <= '0;
			sqrt_q.rad  <= fg ? (rad_t'(sq) << (2 * zlcmd_pkg::FRAC_BITS)) : '0;
		end else if (state_q == F_ROOT) begin
			sqrt_q <= sqrt_next;
		end
	end

`ifndef ASSERT_OFF
	a_push_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_PUSH) && !q_full |=> (state_q == F_IDLE))
		else $error("front did not return to idle after its item was queued");
`endif

endmodule

@@ hw/rtl/zlcmd_queue.sv @@
// Short queue of classified items between the front and the back.
module zlcmd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  zlcmd_pkg::q_push_t  q_push,
	output logic                q_full,
	input  logic                pop,
	output zlcmd_pkg::q_head_t  q_head
);

	typedef logic [zlcmd_pkg::QPTR_W-1:0] ptr_t;
	typedef logic [zlcmd_pkg::QPTR_W:0]   qcnt_t;

	zlcmd_pkg::item_t entry_q [zlcmd_pkg::QUEUE_DEPTH];
	ptr_t             wr_q;
	ptr_t             rd_q;
	qcnt_t            count_q;

	assign q_full       = (count_q == qcnt_t'(zlcmd_pkg::QUEUE_DEPTH));
	assign q_head.empty = (count_q == '0);
	assign q_head.head  = entry_q[rd_q];

	// Pointers wrap on their own since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (q_push.valid) begin
				wr_q <= wr_q + ptr_t'(1);
			end
			if (pop) begin
				rd_q <= rd_q + ptr_t'(1);
			end
			if (q_push.valid && !pop) begin
				count_q <= count_q + qcnt_t'(1);
			end else if (pop && !q_push.valid) begin
				count_q <= count_q - qcnt_t'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (q_push.valid) begin
			entry_q[wr_q] <= q_push.item;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.valid |-> !q_full)
		else $error("item pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_head.empty)
		else $error("item popped from an empty queue");
`endif

endmodule

@@ hw/rtl/zlcmd_back.sv @@
// Back end: accumulates distances per line, divides at the line end, holds the result.
module zlcmd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  zlcmd_pkg::q_head_t q_head,
	output logic               pop,
	zlcmd_result_if.source     result
);

	typedef logic [zlcmd_pkg::SUM_W:0]       sum_ext_t;
	typedef logic [zlcmd_pkg::CNT_W:0]       trial_t;
	typedef logic [zlcmd_pkg::DIV_CNT_W-1:0] dcnt_t;
	typedef logic [zlcmd_pkg::MEAN_W-1:0]    mean_t;

	typedef enum logic [2:0] {
		B_ACC = 3'b001,
		B_DIV = 3'b010,
		B_OUT = 3'b100
	} state_t;

	state_t          state_q;
	zlcmd_pkg::sum_t sum_q;
	zlcmd_pkg::cnt_t cnt_q;
	zlcmd_pkg::sum_t quo_q;
	zlcmd_pkg::cnt_t dvsr_q;
	zlcmd_pkg::cnt_t drem_q;
	dcnt_t           step_q;
	logic            res_valid_q;
	mean_t           mean_q;
	zlcmd_pkg::cnt_t fgcnt_q;

	sum_ext_t        sum_add;
	zlcmd_pkg::sum_t sum_new;
	zlcmd_pkg::cnt_t cnt_new;
	trial_t          trial;
	logic            quo_bit;
	logic            load;
	mean_t           mean_sat;

	assign pop = (state_q == B_ACC) && !q_head.empty;

	// Saturating accumulation of the popped item.
	always_comb begin
		sum_add = sum_ext_t'(sum_q) + sum_ext_t'(q_head.head.distance);
		sum_new = sum_add[zlcmd_pkg::SUM_W] ? '1 : sum_add[zlcmd_pkg::SUM_W-1:0];
		if (q_head.head.fg && (cnt_q != zlcmd_pkg::CNT_MAX)) begin
			cnt_new = cnt_q + zlcmd_pkg::cnt_t'(1);
		end else begin
			cnt_new = cnt_q;
		end
	end

	// One restoring division step.
	always_comb begin
		trial   = {drem_q, quo_q[zlcmd_pkg::SUM_W-1]};
		quo_bit = (trial >= trial_t'(dvsr_q));
	end

	// Empty line gives zero; a quotient beyond the field saturates.
	always_comb begin
		if (dvsr_q == '0) begin
			mean_sat = '0;
		end else if (|quo_q[zlcmd_pkg::SUM_W-1:zlcmd_pkg::MEAN_W]) begin
			mean_sat = '1;
		end else begin
			mean_sat = quo_q[zlcmd_pkg::MEAN_W-1:0];
		end
	end

	assign load = (state_q == B_OUT) && (!res_valid_q || result.ready);

	assign result.valid            = res_valid_q;
	assign result.mean_distance    = mean_q;
	assign result.foreground_count = fgcnt_q;

	// Sequencer, accumulators and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_ACC;
			sum_q       <= '0;
			cnt_q       <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_ACC: begin
					if (pop) begin
						if (q_head.head.last) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							step_q  <= '0;
							state_q <= B_DIV;
						end else begin
							sum_q <= sum_new;
							cnt_q <= cnt_new;
						end
					end
				end
				B_DIV: begin
					step_q <= step_q + dcnt_t'(1);
					if (step_q == dcnt_t'(zlcmd_pkg::DIV_STEPS - 1)) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (load) begin
						state_q <= B_ACC;
					end
				end
				default: state_q <= B_ACC;
			endcase
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Divider and result datapath.
	always_ff @(posedge clk) begin
		if (pop && q_head.head.last) begin
			quo_q  <= sum_new;
			dvsr_q <= cnt_new;
			drem_q <= '0;
		end else if (state_q == B_DIV) begin
			quo_q <= {quo_q[zlcmd_pkg::SUM_W-2:0], quo_bit};
			if (quo_bit) begin
				drem_q <= zlcmd_pkg::cnt_t'(trial - trial_t'(dvsr_q));
			end else begin
				drem_q <= zlcmd_pkg::cnt_t'(trial);
			end
		end
		if (load) begin
			mean_q  <= mean_sat;
			fgcnt_q <= dvsr_q;
		end
	end

`ifndef ASSERT_OFF
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (step_q < dcnt_t'(zlcmd_pkg::DIV_STEPS)))
		else $error("divider step counter ran past the last quotient bit");
	a_mean_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (mean_q != '0) |-> (fgcnt_q != '0))
		else $error("nonzero mean reported for a line without foreground pixels");
`endif

endmodule
